@@ rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int ID_WIDTH    = 16;
   localparam int PRIO_WIDTH  = 8;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef enum logic [0:0] {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      func_type    func;
      logic [15:0] req_id;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_id;
      logic [7:0]  out_priority;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [PRIO_WIDTH-1:0] prio;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } spq_cmd_type;

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
module spq_cell import spq_pkg::*; (
   input  wire logic        clock,
   input  wire spq_cmd_type cmd,
   input  wire logic        valid_here,
   input  wire logic        left_keep,
   input  wire entry_type   left_entry,
   input  wire entry_type   right_entry,
   output logic             keep,
   output entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // stay put if the new entry ranks behind this one (ties go behind)
   assign keep  = valid_here && (entry_ff.prio >= cmd.entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!keep) begin
            entry_in = left_keep ? cmd.entry : left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire

@@ rtl/stable_priority_queue_unit.sv @@
// Latency: a result word appears in the cycle after its request word is taken.
// Throughput: one request word per cycle; every cell updates in parallel on
// insert and remove. The output register is the only stage, and a new
// request is taken whenever it is empty or being drained.
// Reset (synchronous, active high) empties the queue and drops any held result.
`default_nettype none
module stable_priority_queue_unit import spq_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic        accept;
   logic        is_full;
   logic        is_empty;
   spq_cmd_type cmd;

   logic      [DEPTH-1:0] cell_valid;
   logic      [DEPTH-1:0] keep_chain;
   entry_type             entry_chain [DEPTH];

   // Hold the request side only while a finished word waits downstream.
   assign req_stall   = rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign is_full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Broadcast the operation; full inserts and empty removes leave the cells alone.
   always_comb begin
      cmd.insert     = accept && (req_payload.func == FUNC_INSERT) && !is_full;
      cmd.remove     = accept && (req_payload.func == FUNC_REMOVE) && !is_empty;
      cmd.entry.id   = ID_WIDTH'(req_payload.req_id);
      cmd.entry.prio = PRIO_WIDTH'(req_payload.priority_req);
   end

   // Cells form a sorted chain: head at cell 0, occupied cells packed at the front.
   // On insert each cell keeps, takes the new entry, or takes its left neighbor;
   // on remove each cell takes its right neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      assign cell_valid[i] = (COUNT_WIDTH'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = cmd.entry;
      end else begin : g_body
         assign left_keep  = keep_chain[i-1];
         assign left_entry = entry_chain[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = entry_chain[i];
      end else begin : g_inner
         assign right_entry = entry_chain[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid_here  (cell_valid[i]),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (keep_chain[i]),
         .entry       (entry_chain[i])
      );
   end

   // Advance the fill count with the cells.
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   // Build the result word from the state seen before the update; occupancy gives the count after it.
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_id       = '0;
         rsp_in.out_priority = '0;
         rsp_in.occupancy    = 5'(count_in);
         unique case (req_payload.func)
            FUNC_INSERT: begin
               rsp_in.status = is_full ? STATUS_FULL : STATUS_INSERTED;
            end
            FUNC_REMOVE: begin
               if (is_empty) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  rsp_in.status       = STATUS_REMOVED;
                  rsp_in.out_id       = 16'(entry_chain[0].id);
                  rsp_in.out_priority = 8'(entry_chain[0].prio);
               end
            end
            default: begin
               rsp_in.status = STATUS_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import spq_pkg::*;

   // Run limits: CYCLE_LIMIT allows several times the slowest legal run, with its
   // random gaps and stalls per item plus the long receiver hold-off.
   localparam int RANDOM_WORDS     = 1900;
   localparam int LONG_HOLD_AT     = 500;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 8;
   localparam int CYCLE_LIMIT      = 200000;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the sorted ticket list, head at index 0.
   entry_type   shadow_entries [DEPTH];
   int unsigned shadow_count = 0;

   rsp_type      pending_results [$];
   stim_row_type directed_rows [$];
   int      failures = 0;
   int      cycle_count = 0;
   bit      send_burst = 1'b0;
   int      words_sent = 0;

   stable_priority_queue_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Advance the shadow list by one request word and return the result word
   // it must produce. An insert goes in front of the first strictly lower
   // priority, so ties keep arrival order.
   function automatic rsp_type predict_ticket_result(req_type w);
      rsp_type     r;
      int unsigned pos;
      int unsigned i;
      r = '0;
      if (w.func == FUNC_INSERT) begin
         if (shadow_count >= DEPTH) begin
            // full: drop the insert, list untouched
            r.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_entries[pos].prio >= w.priority_req)
               pos++;
            for (i = shadow_count; i > pos; i--)
               shadow_entries[i] = shadow_entries[i - 1];
            shadow_entries[pos].id   = w.req_id;
            shadow_entries[pos].prio = w.priority_req;
            shadow_count++;
            r.status = STATUS_INSERTED;
         end
      end else if (shadow_count == 0) begin
         // empty: nothing to pop, list untouched
         r.status = STATUS_EMPTY;
      end else begin
         r.status       = STATUS_REMOVED;
         r.out_id       = shadow_entries[0].id;
         r.out_priority = shadow_entries[0].prio;
         for (i = 1; i < shadow_count; i++)
            shadow_entries[i - 1] = shadow_entries[i];
         shadow_count--;
      end
      r.occupancy = 5'(shadow_count);
      return r;
   endfunction

   function automatic req_type make_word(func_type f, logic [15:0] id, logic [7:0] pr);
      req_type w;
      w.func         = f;
      w.req_id       = id;
      w.priority_req = pr;
      return w;
   endfunction

   function automatic rsp_type make_result(status_type s, logic [15:0] id, logic [7:0] pr,
                                           logic [4:0] occ);
      rsp_type r;
      r.status       = s;
      r.out_id       = id;
      r.out_priority = pr;
      r.occupancy    = occ;
      return r;
   endfunction

   function automatic void add_row(req_type w, bit typed = 1'b0, rsp_type r = '0);
      stim_row_type row;
      row.word   = w;
      row.typed  = typed;
      row.result = r;
      directed_rows = {directed_rows, row};
   endfunction

   // Offer one request word after a random gap, hold it until taken, then
   // queue the result it must produce.
   task automatic drive_request(req_type w, rsp_type want);
      int gap;
      if (words_sent % 50 == 0)
         send_burst = ($urandom_range(0, 3) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results = {pending_results, want};
      words_sent++;
   endtask

   // Sender: reset, directed table, random traffic, then drain.
   initial begin : request_side
      req_type w;
      rsp_type want;
      int      phase_left;
      int      insert_pct;
      int      pick;
      logic [7:0] pr;

      // Directed table. Typed results are the ones readable at a glance.
      add_row(make_word(FUNC_REMOVE, 16'hFFFF, 8'hFF), 1'b1,
              make_result(STATUS_EMPTY, 16'h0000, 8'h00, 5'd0));
      add_row(make_word(FUNC_INSERT, 16'h0000, 8'h00), 1'b1,
              make_result(STATUS_INSERTED, 16'h0000, 8'h00, 5'd1));
      add_row(make_word(FUNC_INSERT, 16'hFFFF, 8'hFF), 1'b1,
              make_result(STATUS_INSERTED, 16'h0000, 8'h00, 5'd2));
      // equal priorities: these must leave in arrival order
      add_row(make_word(FUNC_INSERT, 16'h0001, 8'h80));
      add_row(make_word(FUNC_INSERT, 16'h0002, 8'h80));
      add_row(make_word(FUNC_INSERT, 16'h0003, 8'h80));
      add_row(make_word(FUNC_INSERT, 16'h0004, 8'h7F));
      add_row(make_word(FUNC_INSERT, 16'h0005, 8'h81));
      add_row(make_word(FUNC_INSERT, 16'h0006, 8'h01));
      add_row(make_word(FUNC_INSERT, 16'h0007, 8'hFF));
      add_row(make_word(FUNC_INSERT, 16'h0008, 8'h00));
      add_row(make_word(FUNC_INSERT, 16'h0009, 8'h80));
      add_row(make_word(FUNC_INSERT, 16'h5A5A, 8'h40));
      add_row(make_word(FUNC_INSERT, 16'hA5A5, 8'hC0));
      add_row(make_word(FUNC_INSERT, 16'h8000, 8'h20));
      add_row(make_word(FUNC_INSERT, 16'h7FFF, 8'hFE));
      add_row(make_word(FUNC_INSERT, 16'h000A, 8'h80));
      // queue is now full: the next insert is dropped even at top priority
      add_row(make_word(FUNC_INSERT, 16'hABCD, 8'hFF), 1'b1,
              make_result(STATUS_FULL, 16'h0000, 8'h00, 5'd16));
      add_row(make_word(FUNC_REMOVE, 16'h0000, 8'h00), 1'b1,
              make_result(STATUS_REMOVED, 16'hFFFF, 8'hFF, 5'd15));
      add_row(make_word(FUNC_REMOVE, 16'h1234, 8'h56));
      add_row(make_word(FUNC_REMOVE, 16'h0000, 8'h00));
      add_row(make_word(FUNC_REMOVE, 16'hFFFF, 8'hFF));
      add_row(make_word(FUNC_REMOVE, 16'h0F0F, 8'hF0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; the shadow list always advances so the random part
      // starts from the right state.
      foreach (directed_rows[k]) begin
         want = predict_ticket_result(directed_rows[k].word);
         if (directed_rows[k].typed)
            want = directed_rows[k].result;
         drive_request(directed_rows[k].word, want);
      end

      // Random traffic in phases: insert-heavy phases push the list to full,
      // remove-heavy ones drain it past empty, balanced ones churn the middle.
      phase_left = 0;
      insert_pct = 50;
      repeat (RANDOM_WORDS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 85;
               end
               1: begin
                  insert_pct = 15;
               end
               default: begin
                  insert_pct = 50;
               end
            endcase
         end
         phase_left--;
         // mostly a few close priorities so ties are common
         pick = $urandom_range(0, 9);
         if (pick < 5)
            pr = 8'($urandom_range(0, 3));
         else if (pick < 6)
            pr = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
         else
            pr = 8'($urandom);
         w = make_word(($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE,
                       16'($urandom), pr);
         drive_request(w, predict_ticket_result(w));
      end
      req_valid <= 1'b0;

      // Drain, then let the output stage run on for DRAIN_CYCLES to misbehave.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   // Receiver: random stalls per word, one long hold-off to back the block up,
   // and a field-by-field check of every result word taken.
   initial begin : result_side
      int      hold;
      int      taken;
      bit      burst;
      rsp_type want;
      taken = 0;
      burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0)
            burst = ($urandom_range(0, 3) == 0);
         hold = burst ? 0 : $urandom_range(0, 7);
         // hold off long enough that the sender runs into req_stall
         if (taken == LONG_HOLD_AT)
            hold = LONG_HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d id %h priority %h occupancy %0d",
                   rsp_payload.status, rsp_payload.out_id, rsp_payload.out_priority,
                   rsp_payload.occupancy);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               failures++;
            end
            if (rsp_payload.out_id !== want.out_id) begin
               $error("out_id: expected %h, got %h", want.out_id, rsp_payload.out_id);
               failures++;
            end
            if (rsp_payload.out_priority !== want.out_priority) begin
               $error("out_priority: expected %h, got %h",
                      want.out_priority, rsp_payload.out_priority);
               failures++;
            end
            if (rsp_payload.occupancy !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d",
                      want.occupancy, rsp_payload.occupancy);
               failures++;
            end
         end
      end
   end

endmodule
